>>> hw/rtl/rsrd_pkg.sv
// Shared types, opcodes and helpers for the run-length sprite row decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsrd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SINGLE = 3'd1,
        PH_RALPHA = 3'd2,
        PH_RIDX   = 3'd3,
        PH_LIT    = 3'd4,
        PH_RUN    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_RUN    = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic load_byte;
        logic load_step;
    } dp_cmd_t;

    typedef struct packed {
        logic run_more;
        logic run_last;
    } dp_status_t;

    localparam logic [1:0] OP_ALPHA   = 2'b00;
    localparam logic [1:0] OP_LITERAL = 2'b01;
    localparam logic [1:0] OP_RUN     = 2'b10;
    localparam logic [1:0] OP_SKIP    = 2'b11;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [7:0] FULL_ALPHA = 8'hFF;
    localparam logic [7:0] END_OF_ROW = 8'h00;

    function automatic logic [7:0] alpha_map(input logic [4:0] a);
        alpha_map = (a == 5'd0) ? 8'd0 : ({a, 3'b000} - 8'd7);
    endfunction

endpackage

>>> hw/rtl/rsrd_ctrl.sv
// Controller for the sprite row decoder: request handshakes and run emission.
// Depends on rsrd_pkg for state, command and status types.
`timescale 1ns / 1ps

module rsrd_ctrl
    import rsrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        in_stall       = !((state_reg == ST_ACCEPT) && out_free);
        cmd.load_byte  = in_valid && (state_reg == ST_ACCEPT) && out_free;
        cmd.load_step  = (state_reg == ST_RUN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd.load_byte && status.run_more)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.load_step && status.run_last)
                begin
                    state_next = ST_ACCEPT;
                end
            end
        endcase
        if (cmd.load_byte || cmd.load_step)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/rsrd_datapath.sv
// Datapath for the sprite row decoder: byte decode, row state, frame size
// registers, run counter and result register. Depends on rsrd_pkg.
`timescale 1ns / 1ps

module rsrd_datapath
    import rsrd_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic [7:0]            data_byte,
    input  logic                  row_start,
    input  logic [COORD_BITS-1:0] row_number,
    input  logic                  frame_start,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  pixel_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [7:0]            palette_index,
    output logic [7:0]            pixel_alpha,
    output logic                  row_done,
    output logic                  interlaced,
    output logic                  last_of_run
);

    localparam int CW = COORD_BITS + 1;

    logic [CW-1:0]         col_reg;
    logic [COORD_BITS-1:0] row_reg;
    phase_t                phase_reg;
    logic [5:0]            cnt_reg;
    logic [7:0]            alpha_reg;
    logic                  flag_reg;
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    logic [5:0]            rem_reg;

    logic                  out_pv_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [7:0]            out_idx_reg;
    logic [7:0]            out_alpha_reg;
    logic                  out_done_reg;
    logic                  out_flag_reg;
    logic                  out_last_reg;

    logic [CW-1:0]         col_next;
    logic [COORD_BITS-1:0] row_next;
    phase_t                phase_next;
    logic [5:0]            cnt_next;
    logic [7:0]            alpha_next;
    logic                  flag_next;

    logic                  ended;
    logic [CW-1:0]         col_at;
    logic [CW-1:0]         col_inc;
    logic [CW-1:0]         width_ext;
    logic [CW-1:0]         room;
    logic [CW-1:0]         cnt_ext;
    logic                  col_in;
    logic                  row_ok;
    logic                  pix_we;
    logic [7:0]            pix_alpha;
    logic [5:0]            run_m;

    assign width_ext = {1'b0, width_reg};

    always_comb
    begin
        flag_next  = frame_start ? 1'b1 : flag_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        alpha_next = alpha_reg;
        ended      = 1'b0;
        pix_we     = 1'b0;
        pix_alpha  = 8'd0;
        run_m      = 6'd0;
        if (row_start)
        begin
            col_next   = '0;
            row_next   = row_number;
            phase_next = PH_IDLE;
            cnt_next   = 6'd0;
            ended      = (width_reg == '0);
        end
        col_at  = col_next;
        col_inc = col_next + CW'(1);
        col_in  = col_next < width_ext;
        row_ok  = row_next < height_reg;
        room    = width_ext - col_next;
        cnt_ext = {{(CW-6){1'b0}}, cnt_next};
        if (!ended)
        begin
            unique case (phase_next)
                PH_IDLE:
                begin
                    if (data_byte == END_OF_ROW)
                    begin
                        ended = 1'b1;
                    end
                    else
                    begin
                        if ((data_byte[7:6] != OP_SKIP) && row_next[0])
                        begin
                            flag_next = 1'b0;
                        end
                        case (data_byte[7:6])
                            OP_ALPHA:
                            begin
                                if (data_byte[5])
                                begin
                                    alpha_next = alpha_map(data_byte[4:0]);
                                    phase_next = PH_SINGLE;
                                end
                                else
                                begin
                                    cnt_next   = {1'b0, data_byte[4:0]};
                                    phase_next = PH_RALPHA;
                                end
                            end
                            OP_LITERAL:
                            begin
                                if (data_byte[5:0] != 6'd0)
                                begin
                                    cnt_next   = data_byte[5:0];
                                    phase_next = PH_LIT;
                                end
                            end
                            OP_RUN:
                            begin
                                cnt_next   = data_byte[5:0];
                                phase_next = PH_RUN;
                            end
                            default:
                            begin
                                col_next = col_next + {{(CW-6){1'b0}}, data_byte[5:0]};
                                ended    = col_next >= width_ext;
                            end
                        endcase
                    end
                end
                PH_SINGLE:
                begin
                    if (!col_in || !row_ok)
                    begin
                        ended = 1'b1;
                    end
                    else
                    begin
                        pix_we    = (alpha_reg != 8'd0);
                        pix_alpha = alpha_reg;
                        col_next  = col_inc;
                        ended     = col_inc >= width_ext;
                    end
                    phase_next = PH_IDLE;
                end
                PH_RALPHA:
                begin
                    alpha_next = alpha_map(data_byte[4:0]);
                    phase_next = PH_RIDX;
                end
                PH_RIDX, PH_RUN:
                begin
                    pix_alpha = (phase_next == PH_RUN) ? FULL_ALPHA : alpha_reg;
                    if (cnt_next != 6'd0)
                    begin
                        if (!col_in || !row_ok)
                        begin
                            ended = 1'b1;
                        end
                        else
                        begin
                            pix_we   = 1'b1;
                            run_m    = (room > cnt_ext) ? cnt_next : room[5:0];
                            ended    = (room <= cnt_ext);
                            col_next = col_inc;
                        end
                    end
                    cnt_next   = 6'd0;
                    phase_next = PH_IDLE;
                end
                PH_LIT:
                begin
                    if (!col_in || !row_ok)
                    begin
                        ended = 1'b1;
                    end
                    else
                    begin
                        pix_we    = 1'b1;
                        pix_alpha = FULL_ALPHA;
                        col_next  = col_inc;
                        ended     = col_inc >= width_ext;
                    end
                    cnt_next = cnt_next - 6'd1;
                    if (cnt_next == 6'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (ended)
        begin
            phase_next = PH_DONE;
        end
    end

    assign status.run_more = run_m > 6'd1;
    assign status.run_last = rem_reg == 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            phase_reg  <= PH_IDLE;
            cnt_reg    <= 6'd0;
            alpha_reg  <= 8'd0;
            flag_reg   <= 1'b1;
            width_reg  <= '0;
            height_reg <= '0;
            rem_reg    <= 6'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    default:          height_reg <= cfg_data;
                endcase
            end
            if (cmd.load_byte)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                alpha_reg <= alpha_next;
                flag_reg  <= flag_next;
                rem_reg   <= run_m - 6'd1;
            end
            else if (cmd.load_step)
            begin
                col_reg <= col_reg + CW'(1);
                rem_reg <= rem_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            out_pv_reg    <= pix_we;
            out_x_reg     <= pix_we ? col_at[COORD_BITS-1:0] : '0;
            out_y_reg     <= pix_we ? row_next : '0;
            out_idx_reg   <= pix_we ? data_byte : 8'd0;
            out_alpha_reg <= pix_we ? pix_alpha : 8'd0;
            out_done_reg  <= (phase_next == PH_DONE);
            out_flag_reg  <= flag_next;
            out_last_reg  <= !(run_m > 6'd1);
        end
        else if (cmd.load_step)
        begin
            out_x_reg    <= col_reg[COORD_BITS-1:0];
            out_last_reg <= (rem_reg == 6'd1);
        end
    end

    assign pixel_valid   = out_pv_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign palette_index = out_idx_reg;
    assign pixel_alpha   = out_alpha_reg;
    assign row_done      = out_done_reg;
    assign interlaced    = out_flag_reg;
    assign last_of_run   = out_last_reg;

endmodule

>>> hw/rtl/rle_sprite_row_decoder_core.sv
// The first result is registered as a coded byte is accepted and shows in the cycle after.
// Throughput: one byte per cycle while the output is not stalled; a run byte writing m
// pixels (m up to 63) holds the input after acceptance until the run counter ends the run.
// Reset (asynchronous, active low): column, row, counters and frame size cleared,
// decoder idle awaiting a command byte, interlace flag set, no result pending.
`timescale 1ns / 1ps

module rle_sprite_row_decoder_core
    import rsrd_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  row_start,
    input  logic [COORD_BITS-1:0] row_number,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pixel_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [7:0]            palette_index,
    output logic [7:0]            pixel_alpha,
    output logic                  row_done,
    output logic                  interlaced,
    output logic                  last_of_run
);

    dp_cmd_t    cmd;
    dp_status_t dp_status;

    rsrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (cmd)
    );

    rsrd_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .row_start     (row_start),
        .row_number    (row_number),
        .frame_start   (frame_start),
        .cmd           (cmd),
        .status        (dp_status),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .palette_index (palette_index),
        .pixel_alpha   (pixel_alpha),
        .row_done      (row_done),
        .interlaced    (interlaced),
        .last_of_run   (last_of_run)
    );

    a_run_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && dp_status.run_more) |=> in_stall)
        else $error("input not held after multi-pixel run request");

    a_run_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_step && dp_status.run_last) |=> (out_valid && last_of_run))
        else $error("final run pixel not marked last");

    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_valid) |-> last_of_run)
        else $error("status result not the only result of its request");

endmodule
